[src/cdq_pkg.sv]
// Shared types and constants for the circular deque block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package cdq_pkg;

	localparam int unsigned CAP_W          = 11;
	localparam int unsigned FUNC_W         = 3;
	localparam int unsigned DEPTH_DEF      = 1024;
	localparam int unsigned DATA_WIDTH_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// Operation codes carried on the func field.
	localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_INS_REAR  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DEL_REAR  = 3'd3;

	typedef enum logic [2:0] {
		OP_INS_FRONT,
		OP_INS_REAR,
		OP_DEL_FRONT,
		OP_DEL_REAR,
		OP_PEEK,
		OP_REFUSE
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic start;
		op_t  op;
		logic rd_done;
		logic cfg_wr;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} status_t;

endpackage

`default_nettype wire

[src/cdq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module cdq_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/cdq_ctrl.sv]
// Controller for the circular deque: handshakes, operation decode and the
// read-wait state machine. Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl
	import cdq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [FUNC_W-1:0] func,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire status_t           status,
	output cmd_t                   cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   can_take;
	logic   accept;
	op_t    op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		case (func)
			FUNC_INS_FRONT: op = status.full ? OP_REFUSE : OP_INS_FRONT;
			FUNC_INS_REAR:  op = status.full ? OP_REFUSE : OP_INS_REAR;
			FUNC_DEL_FRONT: op = status.empty ? OP_REFUSE : OP_DEL_FRONT;
			FUNC_DEL_REAR:  op = status.empty ? OP_REFUSE : OP_DEL_REAR;
			default:        op = OP_PEEK;
		endcase
	end

	always_comb begin
		// A new word is taken only in the idle state, when no capacity write is offered
		// and the result register is free or drains now.
		can_take    = (state_q == ST_IDLE) && !cfg_valid && (!out_valid_q || !out_stall);
		accept      = in_valid && can_take;
		in_stall    = !can_take;
		cfg_ready   = (state_q == ST_IDLE);
		out_valid   = out_valid_q;
		state_d     = state_q;
		out_valid_d = out_valid_q && out_stall;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_DEL_FRONT || op == OP_DEL_REAR) begin
						state_d = ST_READ;
					end else begin
						out_valid_d = 1'b1;
					end
				end
			end
			ST_READ: begin
				state_d     = ST_IDLE;
				out_valid_d = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		cmd.start   = accept;
		cmd.op      = op;
		cmd.rd_done = (state_q == ST_READ);
		cmd.cfg_wr  = cfg_valid && cfg_ready;
	end

endmodule

`default_nettype wire

[src/cdq_dpath.sv]
// Datapath for the circular deque: ring pointers, entry count, cached end
// values, slot storage and the result register. Depends on cdq_pkg, cdq_ram.
`default_nettype none

module cdq_dpath
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire logic [CAP_W-1:0]      capacity,
	output status_t                    status,
	output logic                       ok,
	output logic      [DATA_WIDTH-1:0] front_value,
	output logic      [DATA_WIDTH-1:0] rear_value,
	output logic                       empty_res,
	output logic                       full_res
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned RST_CAP = (int'(CAP_RESET) > DEPTH) ? DEPTH : int'(CAP_RESET);

	logic [AW-1:0]         head_q, tail_q, last_q;
	logic [CW-1:0]         count_q, ecap_q;
	logic [DATA_WIDTH-1:0] front_q, rear_q;
	logic                  pend_front_q;

	logic [CW-1:0]         cfg_cap;
	logic [AW-1:0]         head_back, head_fwd, tail_back, tail_fwd;
	logic                  is_empty, is_full, new_empty;
	logic [CW-1:0]         count_inc;
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [DATA_WIDTH-1:0] zero_w;

	assign zero_w = '0;

	always_comb begin
		// Capacity zero acts as one; values above the storage depth saturate.
		if (capacity == '0) begin
			cfg_cap = CW'(1);
		end else if (32'(capacity) > DEPTH) begin
			cfg_cap = CW'(DEPTH);
		end else begin
			cfg_cap = CW'(capacity);
		end

		head_back = (head_q == '0) ? last_q : head_q - AW'(1);
		head_fwd  = (head_q == last_q) ? '0 : head_q + AW'(1);
		tail_back = (tail_q == '0) ? last_q : tail_q - AW'(1);
		tail_fwd  = (tail_q == last_q) ? '0 : tail_q + AW'(1);

		is_empty  = (count_q == '0);
		is_full   = (count_q == ecap_q);
		count_inc = count_q + CW'(1);
		new_empty = (count_q == '0);

		status.empty = is_empty;
		status.full  = is_full;

		ram_we    = cmd.start && (cmd.op == OP_INS_FRONT || cmd.op == OP_INS_REAR);
		ram_waddr = (cmd.op == OP_INS_FRONT) ? head_back : tail_fwd;
		ram_re    = cmd.start && (cmd.op == OP_DEL_FRONT || cmd.op == OP_DEL_REAR);
		ram_raddr = (cmd.op == OP_DEL_FRONT) ? head_fwd : tail_back;
	end

	cdq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= AW'(RST_CAP - 1);
			last_q  <= AW'(RST_CAP - 1);
			ecap_q  <= CW'(RST_CAP);
			count_q <= '0;
		end else if (cmd.cfg_wr) begin
			head_q  <= '0;
			tail_q  <= AW'(cfg_cap - CW'(1));
			last_q  <= AW'(cfg_cap - CW'(1));
			ecap_q  <= cfg_cap;
			count_q <= '0;
		end else if (cmd.start) begin
			case (cmd.op)
				OP_INS_FRONT: begin
					head_q  <= head_back;
					count_q <= count_inc;
				end
				OP_INS_REAR: begin
					tail_q  <= tail_fwd;
					count_q <= count_inc;
				end
				OP_DEL_FRONT: begin
					head_q  <= head_fwd;
					count_q <= count_q - CW'(1);
				end
				OP_DEL_REAR: begin
					tail_q  <= tail_back;
					count_q <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// End values and the result word carry no reset; they are masked when empty.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			case (cmd.op)
				OP_INS_FRONT: begin
					front_q     <= value;
					rear_q      <= is_empty ? value : rear_q;
					ok          <= 1'b1;
					front_value <= value;
					rear_value  <= is_empty ? value : rear_q;
					empty_res   <= 1'b0;
					full_res    <= (count_inc == ecap_q);
				end
				OP_INS_REAR: begin
					rear_q      <= value;
					front_q     <= is_empty ? value : front_q;
					ok          <= 1'b1;
					front_value <= is_empty ? value : front_q;
					rear_value  <= value;
					empty_res   <= 1'b0;
					full_res    <= (count_inc == ecap_q);
				end
				OP_DEL_FRONT: begin
					pend_front_q <= 1'b1;
				end
				OP_DEL_REAR: begin
					pend_front_q <= 1'b0;
				end
				default: begin
					ok          <= (cmd.op == OP_PEEK);
					front_value <= is_empty ? zero_w : front_q;
					rear_value  <= is_empty ? zero_w : rear_q;
					empty_res   <= is_empty;
					full_res    <= is_full;
				end
			endcase
		end else if (cmd.rd_done) begin
			// The count already reflects the delete; the RAM holds the new end entry.
			ok        <= 1'b1;
			empty_res <= new_empty;
			full_res  <= is_full;
			if (pend_front_q) begin
				front_q     <= ram_rdata;
				front_value <= new_empty ? zero_w : ram_rdata;
				rear_value  <= new_empty ? zero_w : rear_q;
			end else begin
				rear_q      <= ram_rdata;
				front_value <= new_empty ? zero_w : front_q;
				rear_value  <= new_empty ? zero_w : ram_rdata;
			end
		end
	end

endmodule

`default_nettype wire

[src/circular_deque.sv]
// Circular deque top level: a double-ended queue of data words in a ring buffer.
// Input channel (in_valid/in_stall) carries one operation per word: func selects
// insert front, insert rear, delete front, delete rear or peek; value is the
// word to insert. Each operation produces exactly one result word on the output
// channel (out_valid/out_stall): ok, front and rear values after the operation
// (zero when empty), and empty/full flags.
// Inserts, peeks and refused operations: the result register loads at the accepting
// edge. A successful delete first passes through the read state, because the new end
// entry comes out of the slot RAM through its registered read port.
// Unless the receiver or a capacity write stalls the input, one word per cycle is
// taken for inserts, peeks and refused ops; none in a delete's read state.
// The capacity port (cfg_valid/cfg_ready) sets the ring length and empties the
// deque; capacity zero acts as one, values above DEPTH saturate to DEPTH.
// While a capacity write is offered the input stalls, so the two never meet.
// Reset empties the deque with capacity 1024 (or DEPTH if smaller).
// While the receiver stalls, the result word holds and in_stall rises, so no
// new word is taken until the result is delivered or drains in the same cycle.
// Depends on cdq_pkg, cdq_ctrl, cdq_dpath and cdq_ram.
`default_nettype none

module circular_deque
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CAP_W-1:0]      capacity,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic [DATA_WIDTH-1:0] value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       ok,
	output logic      [DATA_WIDTH-1:0] front_value,
	output logic      [DATA_WIDTH-1:0] rear_value,
	output logic                       empty_res,
	output logic                       full_res
);

	cmd_t    cmd;
	status_t status;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cdq_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.capacity    (capacity),
		.status      (status),
		.ok          (ok),
		.front_value (front_value),
		.rear_value  (rear_value),
		.empty_res   (empty_res),
		.full_res    (full_res)
	);

	// The ring always holds at least one slot, so it can never be empty and full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(status.empty && status.full))
		else $error("deque reports empty and full at once");

	// An empty result shows zero at both ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> front_value == '0 && rear_value == '0)
		else $error("empty result carries nonzero end values");

	// A refused operation is an insert into a full deque or a delete from an empty one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> full_res || empty_res)
		else $error("refused operation while neither empty nor full");

	// A delete in flight blocks the input during its read state.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && (cmd.op == OP_DEL_FRONT || cmd.op == OP_DEL_REAR)
		|=> in_stall && !out_valid ##1 out_valid)
		else $error("delete result not produced after the read cycle");

endmodule

`default_nettype wire
